// File: src/nftra_pkg.sv
// ----------------------------------------------------------------------------
// nftra_pkg
// Shared types, constants and helpers of the next-fit tile run allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nftra_pkg;

    localparam int TILE_COUNT  = 1024;
    localparam int LOW_TILE    = 256;
    localparam int SEG_SLOTS   = 19;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = TILE_COUNT / WORD_BITS;
    localparam int WORD_AW     = $clog2(WORD_COUNT);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int TILE_W      = $clog2(TILE_COUNT) + 1;
    localparam int SUM_W       = TILE_W + 1;
    localparam int SEG_IW      = (SEG_SLOTS > 1) ? $clog2(SEG_SLOTS) : 1;
    localparam int BLOCK_TILES = 512;

    typedef enum logic [1:0] {
        FN_BEGIN   = 2'd0,
        FN_MARK    = 2'd1,
        FN_CONTENT = 2'd2,
        FN_ALLOC   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_NOFIT  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] window_key;
        logic [31:0] template_key;
        logic [1:0]  char_block;
        logic [9:0]  tile_index;
        logic [9:0]  run_length;
        logic        nonempty_flag;
    } t_in_beat;

    typedef struct packed {
        logic [9:0] first_tile;
        logic [1:0] status;
    } t_out_beat;

    // Upper bound of the allocation window: min((4 - cb) * 512, TILE_COUNT).
    function automatic logic [TILE_W-1:0] upper_bound(input logic [1:0] cb);
        logic [15:0] prod;
        prod = 16'(3'd4 - {1'b0, cb}) * 16'(BLOCK_TILES);
        if (prod > 16'(TILE_COUNT)) begin
            return TILE_W'(TILE_COUNT);
        end
        return TILE_W'(prod);
    endfunction

endpackage

`default_nettype wire

// File: src/nftra_ram.sv
// ----------------------------------------------------------------------------
// nftra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nftra_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [W-1:0]               i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [W-1:0]               o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/next_fit_tile_run_allocator_core.sv
// ----------------------------------------------------------------------------
// next_fit_tile_run_allocator_core
// Next-fit allocator of contiguous tile runs over word-wide occupancy and
// content maps, with a small table of owned segments.
// ----------------------------------------------------------------------------
//  channel  | signals                                | beat
//  ---------+----------------------------------------+-----------------------
//  in       | i_in_valid, o_in_ready, i_in_beat      | one operation
//  out      | o_out_valid, i_out_ready, o_out_beat   | one result per op
//
//  One operation at a time; o_in_ready is high only when idle.
//  Begin clears the 32 occupancy map words; mark reads and rewrites each
//  map word touched; set content rewrites one content word. Allocate
//  checks about one tile per cycle, rereading each map word entered, then
//  marks the run and merges it into the segment table. After reset a
//  pass clears both maps, taking no beat; a stalled result blocks until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module next_fit_tile_run_allocator_core
    import nftra_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLEAR = 10'b0000000010,
        S_MRD   = 10'b0000000100,
        S_MWR   = 10'b0000001000,
        S_CRD   = 10'b0000010000,
        S_CWR   = 10'b0000100000,
        S_SRD   = 10'b0001000000,
        S_SBIT  = 10'b0010000000,
        S_SEG   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        SK_APPEND  = 2'd0,
        SK_PREPEND = 2'd1,
        SK_INSIDE  = 2'd2
    } t_seg_kind;

    t_state               r_state;
    logic                 r_clr_all;
    logic                 r_alloc;
    logic [WORD_AW-1:0]   r_word;
    logic [9:0]           r_ma;
    logic [9:0]           r_mlast;
    logic [9:0]           r_ci;
    logic                 r_cflag;
    logic [TILE_W-1:0]    r_p;
    logic [TILE_W-1:0]    r_cand;
    logic [9:0]           r_n;
    logic [TILE_W-1:0]    r_hi;
    logic                 r_pass;
    logic                 r_fresh;
    logic [WORD_BITS-1:0] r_wbuf;
    logic [WORD_BITS-1:0] r_cbuf;
    logic [TILE_W-1:0]    r_cursor;
    logic [31:0]          r_own_win;
    logic [31:0]          r_own_tpl;
    logic [9:0]           r_seg_st [SEG_SLOTS];
    logic [10:0]          r_seg_ln [SEG_SLOTS];
    t_out_beat            r_out;

    // RAM ports
    logic                 occ_we, cnt_we;
    logic [WORD_AW-1:0]   occ_waddr, cnt_waddr, raddr;
    logic [WORD_BITS-1:0] occ_wdata, cnt_wdata, occ_rdata, cnt_rdata;

    nftra_ram #(.W(WORD_BITS), .DEPTH(WORD_COUNT)) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (occ_waddr),
        .i_wdata (occ_wdata),
        .i_raddr (raddr),
        .o_rdata (occ_rdata)
    );

    nftra_ram #(.W(WORD_BITS), .DEPTH(WORD_COUNT)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (raddr),
        .o_rdata (cnt_rdata)
    );

    // Mark mask for the current word
    logic [BIT_W-1:0]     lo_b, hi_b;
    logic [WORD_BITS-1:0] mark_mask;

    always_comb begin
        lo_b = (r_word == r_ma[BIT_W +: WORD_AW]) ? r_ma[BIT_W-1:0] : '0;
        hi_b = (r_word == r_mlast[BIT_W +: WORD_AW]) ? r_mlast[BIT_W-1:0]
                                                     : BIT_W'(WORD_BITS - 1);
        mark_mask = ({WORD_BITS{1'b1}} << lo_b) &
                    ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_b));
    end

    // Scan of one tile
    logic [WORD_BITS-1:0] occ_w, cnt_w, occ_new;
    logic [BIT_W-1:0]     bsel;
    logic                 ob, cb, inseg, kill, usable, hit_run, pass_end;
    logic [TILE_W-1:0]    p_next, cand_next;
    logic [SUM_W-1:0]     cand_end;

    always_comb begin
        occ_w  = r_fresh ? occ_rdata : r_wbuf;
        cnt_w  = r_fresh ? cnt_rdata : r_cbuf;
        bsel   = r_p[BIT_W-1:0];
        ob     = occ_w[bsel];
        cb     = cnt_w[bsel];
        inseg  = 1'b0;
        for (int i = 0; i < SEG_SLOTS; i++) begin
            if (r_seg_ln[i] != '0 && r_p >= TILE_W'(r_seg_st[i]) &&
                (r_p - TILE_W'(r_seg_st[i])) < r_seg_ln[i]) begin
                inseg = 1'b1;
            end
        end
        kill      = !ob && cb && !inseg;
        usable    = !ob && (!cb || inseg);
        occ_new   = occ_w | (WORD_BITS'(kill) << bsel);
        p_next    = r_p + 1'b1;
        hit_run   = usable && (SUM_W'(p_next) == SUM_W'(r_cand) + SUM_W'(r_n));
        cand_next = usable ? r_cand : p_next;
        cand_end  = SUM_W'(cand_next) + SUM_W'(r_n);
        pass_end  = cand_end > SUM_W'(r_hi);
    end

    // Segment merge lookup: first live entry that touches or holds the run
    logic              seg_found;
    logic [SEG_IW-1:0] seg_idx;
    t_seg_kind         seg_kind;

    always_comb begin
        seg_found = 1'b0;
        seg_idx   = '0;
        seg_kind  = SK_INSIDE;
        for (int i = 0; i < SEG_SLOTS; i++) begin
            if (!seg_found && r_seg_ln[i] != '0) begin
                if (SUM_W'(r_seg_st[i]) + SUM_W'(r_seg_ln[i]) == SUM_W'(r_cand)) begin
                    seg_found = 1'b1;
                    seg_idx   = SEG_IW'(i);
                    seg_kind  = SK_APPEND;
                end else if (SUM_W'(r_cand) + SUM_W'(r_n) == SUM_W'(r_seg_st[i])) begin
                    seg_found = 1'b1;
                    seg_idx   = SEG_IW'(i);
                    seg_kind  = SK_PREPEND;
                end else if (r_cand >= TILE_W'(r_seg_st[i]) &&
                             (r_cand - TILE_W'(r_seg_st[i])) < r_seg_ln[i]) begin
                    seg_found = 1'b1;
                    seg_idx   = SEG_IW'(i);
                    seg_kind  = SK_INSIDE;
                end
            end
        end
    end

    // RAM control
    always_comb begin
        occ_we    = 1'b0;
        occ_waddr = r_word;
        occ_wdata = '0;
        cnt_we    = 1'b0;
        cnt_waddr = r_word;
        cnt_wdata = '0;
        raddr     = r_word;
        unique case (r_state)
            S_CLEAR: begin
                occ_we = 1'b1;
                cnt_we = r_clr_all;
            end
            S_MWR: begin
                occ_we    = 1'b1;
                occ_wdata = occ_rdata | mark_mask;
            end
            S_CRD: begin
                raddr = r_ci[BIT_W +: WORD_AW];
            end
            S_CWR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_ci[BIT_W +: WORD_AW];
                cnt_wdata = cnt_rdata;
                cnt_wdata[r_ci[BIT_W-1:0]] = r_cflag;
            end
            S_SRD: begin
                raddr = r_p[BIT_W +: WORD_AW];
            end
            S_SBIT: begin
                occ_we    = 1'b1;
                occ_waddr = r_p[BIT_W +: WORD_AW];
                occ_wdata = occ_new;
            end
            S_IDLE, S_MRD, S_SEG, S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Decode of an accepted allocate
    logic [TILE_W-1:0] a_hi, a_start;
    logic              a_reject, a_newown;
    logic [SUM_W-1:0]  a_end;
    logic [10:0]       m_end;

    always_comb begin
        a_hi     = upper_bound(i_in_beat.char_block);
        a_reject = (i_in_beat.run_length == '0) ||
                   ((a_hi - TILE_W'(LOW_TILE)) < TILE_W'(i_in_beat.run_length));
        a_newown = (r_own_win != i_in_beat.window_key) ||
                   (r_own_tpl != i_in_beat.template_key);
        a_start  = a_newown ? '0 : r_cursor;
        if (a_start < TILE_W'(LOW_TILE) || a_start >= a_hi) begin
            a_start = TILE_W'(LOW_TILE);
        end
        a_end = SUM_W'(a_start) + SUM_W'(i_in_beat.run_length);
        m_end = 11'(i_in_beat.tile_index) + 11'(i_in_beat.run_length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_all <= 1'b1;
            r_word    <= '0;
            r_alloc   <= 1'b0;
            r_cursor  <= '0;
            r_own_win <= '0;
            r_own_tpl <= '0;
            for (int i = 0; i < SEG_SLOTS; i++) begin
                r_seg_st[i] <= '0;
                r_seg_ln[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_out.first_tile <= '0;
                        r_out.status     <= ST_DONE;
                        r_alloc          <= 1'b0;
                        case (t_func'(i_in_beat.func))
                            FN_BEGIN: begin
                                if (a_newown) begin
                                    r_own_win <= i_in_beat.window_key;
                                    r_own_tpl <= i_in_beat.template_key;
                                    r_cursor  <= '0;
                                end
                                r_clr_all <= 1'b0;
                                r_word    <= '0;
                                r_state   <= S_CLEAR;
                            end
                            FN_MARK: begin
                                r_ma   <= i_in_beat.tile_index;
                                r_word <= i_in_beat.tile_index[BIT_W +: WORD_AW];
                                // clip at the end of the map
                                if (m_end > 11'(TILE_COUNT)) begin
                                    r_mlast <= 10'(TILE_COUNT - 1);
                                end else begin
                                    r_mlast <= 10'(m_end - 11'd1);
                                end
                                r_state <= (i_in_beat.run_length == '0) ? S_OUT : S_MRD;
                            end
                            FN_CONTENT: begin
                                r_ci    <= i_in_beat.tile_index;
                                r_cflag <= i_in_beat.nonempty_flag;
                                r_state <= S_CRD;
                            end
                            default: begin
                                if (a_reject) begin
                                    r_out.status <= ST_REJECT;
                                    r_state      <= S_OUT;
                                end else begin
                                    if (a_newown) begin
                                        r_own_win <= i_in_beat.window_key;
                                        r_own_tpl <= i_in_beat.template_key;
                                        r_cursor  <= '0;
                                    end
                                    r_out.status <= ST_NOFIT;
                                    r_n          <= i_in_beat.run_length;
                                    r_hi         <= a_hi;
                                    if (a_end <= SUM_W'(a_hi)) begin
                                        r_p    <= a_start;
                                        r_cand <= a_start;
                                        r_pass <= 1'b0;
                                    end else begin
                                        r_p    <= TILE_W'(LOW_TILE);
                                        r_cand <= TILE_W'(LOW_TILE);
                                        r_pass <= 1'b1;
                                    end
                                    r_state <= S_SRD;
                                end
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_word <= r_word + 1'b1;
                    if (r_word == WORD_AW'(WORD_COUNT - 1)) begin
                        r_state   <= r_clr_all ? S_IDLE : S_OUT;
                        r_clr_all <= 1'b0;
                    end
                end
                S_MRD: begin
                    r_state <= S_MWR;
                end
                S_MWR: begin
                    r_word <= r_word + 1'b1;
                    if (r_word == r_mlast[BIT_W +: WORD_AW]) begin
                        r_state <= r_alloc ? S_SEG : S_OUT;
                    end else begin
                        r_state <= S_MRD;
                    end
                end
                S_CRD: begin
                    r_state <= S_CWR;
                end
                S_CWR: begin
                    r_state <= S_OUT;
                end
                S_SRD: begin
                    r_fresh <= 1'b1;
                    r_state <= S_SBIT;
                end
                S_SBIT: begin
                    r_fresh <= 1'b0;
                    r_wbuf  <= occ_new;
                    r_cbuf  <= cnt_w;
                    if (hit_run) begin
                        // grant: mark the run, then merge it into the table
                        r_cursor         <= p_next;
                        r_out.first_tile <= r_cand[9:0];
                        r_out.status     <= ST_DONE;
                        r_alloc          <= 1'b1;
                        r_ma             <= r_cand[9:0];
                        r_mlast          <= r_p[9:0];
                        r_word           <= r_cand[BIT_W +: WORD_AW];
                        r_state          <= S_MRD;
                    end else if (pass_end) begin
                        if (!r_pass) begin
                            r_pass  <= 1'b1;
                            r_p     <= TILE_W'(LOW_TILE);
                            r_cand  <= TILE_W'(LOW_TILE);
                            r_state <= S_SRD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_p    <= p_next;
                        r_cand <= cand_next;
                        if (p_next[BIT_W-1:0] == '0) begin
                            r_state <= S_SRD;
                        end
                    end
                end
                S_SEG: begin
                    if (!seg_found) begin
                        // evict the oldest entry
                        for (int i = 0; i + 1 < SEG_SLOTS; i++) begin
                            r_seg_st[i] <= r_seg_st[i+1];
                            r_seg_ln[i] <= r_seg_ln[i+1];
                        end
                        r_seg_st[SEG_SLOTS-1] <= r_cand[9:0];
                        r_seg_ln[SEG_SLOTS-1] <= 11'(r_n);
                    end else begin
                        case (seg_kind)
                            SK_APPEND: begin
                                r_seg_ln[seg_idx] <= r_seg_ln[seg_idx] + 11'(r_n);
                            end
                            SK_PREPEND: begin
                                r_seg_st[seg_idx] <= r_cand[9:0];
                                r_seg_ln[seg_idx] <= r_seg_ln[seg_idx] + 11'(r_n);
                            end
                            default: begin
                            end
                        endcase
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the next-fit tile run allocator: a queue of
// operation beats feeds a clocked driver, a monitor compares every result
// beat against an in-bench model of the maps, segment table and cursor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import nftra_pkg::*;

    localparam int IN_W = $bits(t_in_beat);

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_beat   i_in_beat;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_beat  o_out_beat;

    next_fit_tile_run_allocator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_beat (o_out_beat)
    );

    // model state
    bit          occ_map [TILE_COUNT];
    bit          busy_map[TILE_COUNT];
    int unsigned seg_base[SEG_SLOTS];
    int unsigned seg_len [SEG_SLOTS];
    int unsigned cursor;
    logic [31:0] own_win;
    logic [31:0] own_tpl;

    t_in_beat    op_queue[$];
    t_out_beat   result_queue[$];
    int          fail_count;
    int          cycle_count;
    bit          quiet;          // no idling in the last part
    bit          out_hold_req;   // long receiver hold-off
    int          hold_left;
    int          gap_left;
    int          stall_left;
    bit          send_paused;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    function automatic bit owned_tile(int unsigned t);
        for (int i = 0; i < SEG_SLOTS; i++) begin
            if (seg_len[i] != 0 && t >= seg_base[i] && t - seg_base[i] < seg_len[i]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void merge_segment(int unsigned t, int unsigned n);
        for (int i = 0; i < SEG_SLOTS; i++) begin
            if (seg_len[i] == 0) continue;
            if (seg_base[i] + seg_len[i] == t) begin
                seg_len[i] = (seg_len[i] + n) & 11'h7FF;
                return;
            end
            if (t + n == seg_base[i]) begin
                seg_base[i] = t & 10'h3FF;
                seg_len[i]  = (seg_len[i] + n) & 11'h7FF;
                return;
            end
            if (t >= seg_base[i] && t - seg_base[i] < seg_len[i]) return;
        end
        // evict the oldest
        for (int i = 0; i + 1 < SEG_SLOTS; i++) begin
            seg_base[i] = seg_base[i+1];
            seg_len[i]  = seg_len[i+1];
        end
        seg_base[SEG_SLOTS-1] = t & 10'h3FF;
        seg_len[SEG_SLOTS-1]  = n & 11'h7FF;
    endfunction

    function automatic bit tile_free(int unsigned t);
        if (t >= TILE_COUNT || busy_map[t]) return 1'b0;
        if (occ_map[t] && !owned_tile(t)) begin
            busy_map[t] = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit claim_run(int unsigned t, int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (!tile_free(t + i)) return 1'b0;
        end
        for (int unsigned i = 0; i < n; i++) busy_map[t+i] = 1'b1;
        cursor = (t + n) & 11'h7FF;
        merge_segment(t, n);
        return 1'b1;
    endfunction

    function automatic t_out_beat predict_result(t_in_beat b);
        t_out_beat   r;
        int unsigned hi;
        int unsigned n;
        int unsigned s;
        r.first_tile = '0;
        r.status     = ST_DONE;
        case (t_func'(b.func))
            FN_BEGIN: begin
                if (own_win != b.window_key || own_tpl != b.template_key) begin
                    own_win = b.window_key;
                    own_tpl = b.template_key;
                    cursor  = 0;
                end
                foreach (busy_map[i]) busy_map[i] = 1'b0;
            end
            FN_MARK: begin
                for (int unsigned i = 0; i < b.run_length && b.tile_index + i < TILE_COUNT; i++)
                    busy_map[b.tile_index + i] = 1'b1;
            end
            FN_CONTENT: occ_map[b.tile_index] = b.nonempty_flag;
            default: begin
                hi = (4 - b.char_block) * 512;
                if (hi > TILE_COUNT) hi = TILE_COUNT;
                n = b.run_length;
                if (n == 0 || hi - LOW_TILE < n) begin
                    r.status = ST_REJECT;
                    return r;
                end
                if (own_win != b.window_key || own_tpl != b.template_key) begin
                    own_win = b.window_key;
                    own_tpl = b.template_key;
                    cursor  = 0;
                end
                s = cursor;
                if (s < LOW_TILE || s >= hi) s = LOW_TILE;
                for (int unsigned t = s; t + n <= hi; t++) begin
                    if (claim_run(t, n)) begin
                        r.first_tile = 10'(t);
                        return r;
                    end
                end
                for (int unsigned t = LOW_TILE; t + n <= hi; t++) begin
                    if (claim_run(t, n)) begin
                        r.first_tile = 10'(t);
                        return r;
                    end
                end
                r.status = ST_NOFIT;
            end
        endcase
        return r;
    endfunction

    function automatic t_in_beat make_op(logic [1:0] f, logic [31:0] w, logic [31:0] p,
                                         logic [1:0] cb, logic [9:0] idx, logic [9:0] len,
                                         logic fl);
        t_in_beat b;
        b.func = f; b.window_key = w; b.template_key = p; b.char_block = cb;
        b.tile_index = idx; b.run_length = len; b.nonempty_flag = fl;
        return b;
    endfunction

    // random operation; mostly a few owners, short runs, allocs dominate
    function automatic t_in_beat random_op();
        t_in_beat    b;
        int unsigned k;
        logic [31:0] keys[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_0001};
        b = t_in_beat'(IN_W'({$urandom, $urandom, $urandom}));
        k = $urandom_range(0, 99);
        if (k < 6)       b.func = FN_BEGIN;
        else if (k < 20) b.func = FN_MARK;
        else if (k < 45) b.func = FN_CONTENT;
        else             b.func = FN_ALLOC;
        if ($urandom_range(0, 9) != 0) begin
            b.window_key   = keys[$urandom_range(0, 1)];
            b.template_key = keys[$urandom_range(2, 3)];
        end
        if (b.func == FN_ALLOC && $urandom_range(0, 19) != 0)
            b.run_length = 10'($urandom_range(1, 24));
        else if (b.func == FN_MARK && $urandom_range(0, 3) != 0)
            b.run_length = 10'($urandom_range(0, 40));
        if (b.func == FN_CONTENT && $urandom_range(0, 2) != 0)
            b.tile_index = 10'($urandom_range(LOW_TILE, 700));
        return b;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                gap_left   <= $urandom_range(1, 10) - 1;
                i_in_valid <= 1'b0;
            end else if (op_queue.size() != 0 && !send_paused) begin
                i_in_beat  <= op_queue[0];
                result_queue.push_back(predict_result(op_queue.pop_front()));
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver ready pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (out_hold_req) begin
            hold_left   <= 400;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left  <= $urandom_range(1, 10) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected beat", o_out_beat.first_tile, -1);
            end else begin
                if (o_out_beat.first_tile !== result_queue[0].first_tile)
                    report_mismatch("first_tile", o_out_beat.first_tile,
                                    result_queue[0].first_tile);
                if (o_out_beat.status !== result_queue[0].status)
                    report_mismatch("status", o_out_beat.status, result_queue[0].status);
                void'(result_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 20_000_000) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_in_beat b;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_ready = 1'b0; i_in_beat = '0;
        fail_count = 0; cycle_count = 0; quiet = 0; out_hold_req = 0;
        hold_left = 0; gap_left = 0; stall_left = 0; send_paused = 0;
        own_win = '0; own_tpl = '0; cursor = 0;
        foreach (occ_map[i]) begin occ_map[i] = 0; busy_map[i] = 0; end
        foreach (seg_len[i]) begin seg_len[i] = 0; seg_base[i] = 0; end

        // directed: rejects, every char block, marks past the end, content,
        // owned-segment reuse, no-fit, owner change at allocate
        op_queue.push_back(make_op(FN_ALLOC, 0, 0, 0, 0, 0, 0));
        op_queue.push_back(make_op(FN_ALLOC, 0, 0, 3, 0, 1, 0));
        op_queue.push_back(make_op(FN_ALLOC, 0, 0, 2, 0, 769, 0));
        op_queue.push_back(make_op(FN_ALLOC, 0, 0, 2, 0, 768, 0));
        op_queue.push_back(make_op(FN_ALLOC, 0, 0, 0, 0, 1, 1));
        op_queue.push_back(make_op(FN_BEGIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 1023, 1023, 1));
        op_queue.push_back(make_op(FN_MARK, 0, 0, 0, 1000, 1023, 0));
        op_queue.push_back(make_op(FN_CONTENT, 0, 0, 0, 300, 0, 1));
        op_queue.push_back(make_op(FN_CONTENT, 0, 0, 0, 1023, 0, 1));
        op_queue.push_back(make_op(FN_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 60, 0));
        op_queue.push_back(make_op(FN_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 700, 0));
        op_queue.push_back(make_op(FN_CONTENT, 0, 0, 0, 256, 0, 1));
        op_queue.push_back(make_op(FN_BEGIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0));
        op_queue.push_back(make_op(FN_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 4, 0));
        op_queue.push_back(make_op(FN_ALLOC, 32'h1, 32'h2, 1, 0, 4, 0));
        op_queue.push_back(make_op(FN_MARK, 0, 0, 0, 0, 0, 0));
        op_queue.push_back(make_op(FN_CONTENT, 0, 0, 0, 256, 0, 0));
        op_queue.push_back(make_op(FN_ALLOC, 32'h1, 32'h2, 0, 1023, 1023, 1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 1600; i++) begin
            b = random_op();
            op_queue.push_back(b);
            if (i == 400) begin
                // long receiver hold-off while the sender keeps offering
                wait (op_queue.size() < 200);
                out_hold_req = 1'b1;
                @(posedge i_clk);
                @(posedge i_clk);
                out_hold_req = 1'b0;
            end
            if (i == 800) begin
                // sender pause until everything has drained
                wait (op_queue.size() == 0);
                send_paused = 1'b1;
                wait (result_queue.size() == 0);
                send_paused = 1'b0;
            end
            if (i == 1300) quiet = 1'b1;
        end
        wait (op_queue.size() == 0 && result_queue.size() == 0);
        repeat (2000) @(posedge i_clk);
        if (fail_count == 0 && result_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
